[rtl/glr_pkg.sv]
`default_nettype none
package glr_pkg;

    // Widest cell index over the supported coordinate range.
    localparam int CELL_W = 10;
    localparam int OUT_W = 11;
    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] MIN_CELL = 8'd16;

    typedef struct packed {
        logic              single;
        logic              cols;
        logic              pos;
        logic              up;
        logic [CELL_W-1:0] sx;
        logic [CELL_W-1:0] sy;
        logic [CELL_W-1:0] n;
        logic [CELL_W-1:0] m;
    } t_job;

endpackage
`default_nettype wire

[rtl/grid_line_run_rasterizer.sv]
// Grid line rasterizer: draws a segment as a stair of grid-aligned rectangles.
// Input channel: i_valid / o_stall carry one segment beat (two endpoints).
// Output channel: o_valid / i_stall carry one rectangle beat; o_last_rect
// marks the final rectangle of a segment, and at most MAX_CELLS are sent.
// The cell size is written through i_cfg_we / i_cfg_data; the user must
// write it only while idle, as the block does not enforce this. Values
// below 16 are taken as 16. The front snaps the bounding box with four
// serial divisions, then queues the segment for the back; o_stall stays
// high until it is queued. The back runs one serial division per rectangle;
// a single box needs none. For segments of several rectangles, the serial
// division in the back sets the throughput.
// A two-entry queue lets the front take new segments while the back works.
// The output beat sits in a register; while i_stall is high it holds and the
// back waits with its next rectangle. Reset empties all stages and sets the
// cell size to 16; no clearing pass is needed.
`default_nettype none
module grid_line_run_rasterizer #(
    parameter int COORD_BITS = 10,
    parameter int MAX_CELLS = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [glr_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [COORD_BITS-1:0]     i_first_x,
    input  wire logic [COORD_BITS-1:0]     i_first_y,
    input  wire logic [COORD_BITS-1:0]     i_second_x,
    input  wire logic [COORD_BITS-1:0]     i_second_y,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_left,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_top,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_width,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_height,
    output logic                           o_last_rect
);
    logic [glr_pkg::CFG_W-1:0] r_cell;
    logic                      w_push, w_pop, w_full, w_empty;
    glr_pkg::t_job             w_job_in, w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= glr_pkg::MIN_CELL;
        end else if (i_cfg_we) begin
            r_cell <= (i_cfg_data < glr_pkg::MIN_CELL) ? glr_pkg::MIN_CELL : i_cfg_data;
        end
    end

    glr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cell(r_cell),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_first_x(i_first_x), .i_first_y(i_first_y),
        .i_second_x(i_second_x), .i_second_y(i_second_y),
        .i_full(w_full), .o_push(w_push), .o_job(w_job_in)
    );

    glr_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_job_in),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_job(w_job_out)
    );

    glr_back #(.COORD_BITS(COORD_BITS), .MAX_CELLS(MAX_CELLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cell(r_cell),
        .i_empty(w_empty), .i_job(w_job_out), .o_pop(w_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_rect_left(o_rect_left), .o_rect_top(o_rect_top),
        .o_rect_width(o_rect_width), .o_rect_height(o_rect_height),
        .o_last_rect(o_last_rect)
    );

`ifndef SYNTHESIS
    a_cell_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cell >= glr_pkg::MIN_CELL)
        else $error("cell size below floor");
`endif
endmodule
`default_nettype wire

[rtl/glr_div.sv]
`default_nettype none
module glr_div #(
    parameter int NW = 10,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [DW:0]      w_sh;
    logic [DW:0]      w_diff;
    logic [NW-1:0]    n_quo;
    logic [DW-1:0]    n_rem;

    always_comb begin
        w_sh   = {r_rem, r_quo[NW-1]};
        w_diff = w_sh - {1'b0, r_den};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_diff[DW-1:0];
            n_quo = {r_quo[NW-2:0], 1'b1};
        end else begin
            n_rem = w_sh[DW-1:0];
            n_quo = {r_quo[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

[rtl/glr_front.sv]
`default_nettype none
module glr_front #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [glr_pkg::CFG_W-1:0] i_cell,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [COORD_BITS-1:0]   i_first_x,
    input  wire logic [COORD_BITS-1:0]   i_first_y,
    input  wire logic [COORD_BITS-1:0]   i_second_x,
    input  wire logic [COORD_BITS-1:0]   i_second_y,
    input  wire logic                    i_full,
    output logic                         o_push,
    output glr_pkg::t_job                o_job
);
    localparam int KW = COORD_BITS - 2;
    localparam int CW = glr_pkg::CELL_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state                  r_state;
    logic [1:0]              r_idx;
    logic                    r_start;
    logic [COORD_BITS-1:0]   r_num;
    logic [COORD_BITS-1:0]   r_maxx, r_miny, r_maxy;
    logic [KW-1:0]           r_sx, r_ex, r_sy, r_ey;
    logic                    r_cols, r_pos, r_up;
    logic                    w_done;
    logic [COORD_BITS-1:0]   w_quo;
    logic [glr_pkg::CFG_W-1:0] w_rem;
    logic [KW-1:0]           w_q;
    logic [COORD_BITS-1:0]   w_next;
    logic [COORD_BITS-1:0]   w_dx, w_dy;
    logic [KW-1:0]           w_wc, w_hc;

    glr_div #(.NW(COORD_BITS), .DW(glr_pkg::CFG_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_num(r_num),
        .i_den(i_cell), .o_done(w_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    always_comb begin
        w_q = w_quo[KW-1:0];
        if (r_idx[0] && w_rem != '0) begin
            w_q = w_q + 1'b1;
        end
        unique case (r_idx)
            2'd0:    w_next = r_maxx;
            2'd1:    w_next = r_miny;
            default: w_next = r_maxy;
        endcase
        w_dx = (i_first_x > i_second_x) ? i_first_x - i_second_x : i_second_x - i_first_x;
        w_dy = (i_first_y > i_second_y) ? i_first_y - i_second_y : i_second_y - i_first_y;
        w_wc = r_ex - r_sx;
        w_hc = r_ey - r_sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_maxx  <= (i_first_x > i_second_x) ? i_first_x : i_second_x;
                        r_miny  <= (i_first_y < i_second_y) ? i_first_y : i_second_y;
                        r_maxy  <= (i_first_y > i_second_y) ? i_first_y : i_second_y;
                        r_num   <= (i_first_x < i_second_x) ? i_first_x : i_second_x;
                        r_cols  <= w_dx < w_dy;
                        r_pos   <= (i_first_x == i_second_x) || (i_first_y == i_second_y)
                                   || ((i_first_x > i_second_x) == (i_first_y > i_second_y));
                        r_up    <= (w_dx < w_dy) ? (i_first_y <= i_second_y)
                                                 : (i_first_x <= i_second_x);
                        r_idx   <= '0;
                        r_start <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        unique case (r_idx)
                            2'd0:    r_sx <= w_q;
                            2'd1:    r_ex <= w_q;
                            2'd2:    r_sy <= w_q;
                            default: r_ey <= w_q;
                        endcase
                        if (r_idx == 2'd3) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_num   <= w_next;
                            r_start <= 1'b1;
                        end
                    end
                end
                default: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_stall      = (r_state != S_IDLE);
        o_push       = (r_state == S_PUSH) && !i_full;
        o_job.single = (w_wc <= KW'(1)) || (w_hc <= KW'(1));
        o_job.cols   = r_cols;
        o_job.pos    = r_pos;
        o_job.up     = r_up;
        o_job.sx     = CW'(r_sx);
        o_job.sy     = CW'(r_sy);
        o_job.n      = r_cols ? CW'(w_wc) : CW'(w_hc);
        o_job.m      = r_cols ? CW'(w_hc) : CW'(w_wc);
    end

`ifndef SYNTHESIS
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_ex >= r_sx) && (r_ey >= r_sy))
        else $error("snapped box has negative extent");
`endif
endmodule
`default_nettype wire

[rtl/glr_fifo.sv]
`default_nettype none
module glr_fifo (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  glr_pkg::t_job i_job,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_empty,
    output glr_pkg::t_job o_job
);
    glr_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");
`endif
endmodule
`default_nettype wire

[rtl/glr_back.sv]
`default_nettype none
module glr_back #(
    parameter int COORD_BITS = 10,
    parameter int MAX_CELLS = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [glr_pkg::CFG_W-1:0] i_cell,
    input  wire logic                      i_empty,
    input  glr_pkg::t_job                  i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_left,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_top,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_width,
    output logic [glr_pkg::OUT_W-1:0]      o_rect_height,
    output logic                           o_last_rect
);
    localparam int KW = COORD_BITS - 2;
    localparam int PW = KW + glr_pkg::CFG_W;
    localparam int OW = glr_pkg::OUT_W;

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_FILL} t_state;

    t_state          r_state;
    logic            r_start;
    logic            r_single, r_cols, r_pos, r_up;
    logic [KW-1:0]   r_sx, r_sy, r_n, r_m;
    logic [KW-1:0]   r_j, r_q, r_prevq;
    logic [2*KW-1:0] r_acc;
    logic            r_ov;
    logic            n_ov;
    logic [OW-1:0]   r_left, r_top, r_width, r_height;
    logic            r_last;
    logic            w_done;
    logic [2*KW-1:0] w_quo;
    logic [KW-1:0]   w_rem;
    logic [KW-1:0]   w_q;
    logic [KW-1:0]   c_left, c_top, c_w, c_h, w_step, w_far;
    logic            w_last, w_free;

    glr_div #(.NW(2*KW), .DW(KW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_num(r_acc),
        .i_den(r_n), .o_done(w_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    function automatic logic [OW-1:0] f_scale(input logic [KW-1:0] v,
                                              input logic [glr_pkg::CFG_W-1:0] c);
        logic [PW-1:0] p;
        p = PW'(v) * PW'(c);
        if (p > PW'({OW{1'b1}})) begin
            return {OW{1'b1}};
        end
        return p[OW-1:0];
    endfunction

    always_comb begin
        w_q = w_quo[KW-1:0];
        if (r_up && w_rem != '0) begin
            w_q = w_q + 1'b1;
        end
        w_free = !r_ov || !i_stall;
        n_ov   = ((r_state == B_FILL) && w_free) || (r_ov && i_stall);
        w_last = r_single || (r_j == r_n - 1'b1) || (r_j == KW'(MAX_CELLS - 1));
        w_far  = r_pos ? r_j : r_n - r_j - 1'b1;
        w_step = r_q - r_prevq;
        if (r_single) begin
            c_left = r_sx;
            c_top  = r_sy;
            c_w    = r_cols ? r_n : r_m;
            c_h    = r_cols ? r_m : r_n;
        end else if (r_cols) begin
            c_left = r_sx + w_far;
            c_top  = r_sy + r_prevq;
            c_w    = KW'(1);
            c_h    = w_step;
        end else begin
            c_left = r_sx + r_prevq;
            c_top  = r_sy + w_far;
            c_w    = w_step;
            c_h    = KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_start <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_start <= 1'b0;
            r_ov    <= n_ov;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_single <= i_job.single;
                        r_cols   <= i_job.cols;
                        r_pos    <= i_job.pos;
                        r_up     <= i_job.up;
                        r_sx     <= i_job.sx[KW-1:0];
                        r_sy     <= i_job.sy[KW-1:0];
                        r_n      <= i_job.n[KW-1:0];
                        r_m      <= i_job.m[KW-1:0];
                        r_acc    <= (2*KW)'(i_job.m[KW-1:0]);
                        r_j      <= '0;
                        r_prevq  <= '0;
                        if (i_job.single) begin
                            r_state <= B_FILL;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    if (w_done) begin
                        r_q     <= w_q;
                        r_state <= B_FILL;
                    end
                end
                default: begin
                    if (w_free) begin
                        r_left   <= f_scale(c_left, i_cell);
                        r_top    <= f_scale(c_top, i_cell);
                        r_width  <= f_scale(c_w, i_cell);
                        r_height <= f_scale(c_h, i_cell);
                        r_last   <= w_last;
                        if (w_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_acc   <= r_acc + (2*KW)'(r_m);
                            r_prevq <= r_q;
                            r_start <= 1'b1;
                            r_state <= B_DIV;
                        end
                    end
                end
            endcase
        end
    end

    assign o_pop         = (r_state == B_IDLE) && !i_empty;
    assign o_valid       = r_ov;
    assign o_rect_left   = r_left;
    assign o_rect_top    = r_top;
    assign o_rect_width  = r_width;
    assign o_rect_height = r_height;
    assign o_last_rect   = r_last;

`ifndef SYNTHESIS
    a_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FILL && !r_single) |-> (r_q >= r_prevq))
        else $error("strip edge moved backward");
    a_strip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FILL && !r_single) |-> (r_j < r_n))
        else $error("strip index past end");
`endif
endmodule
`default_nettype wire

[sim/grid_line_run_rasterizer_tb.sv]
`timescale 1ns / 1ps
module grid_line_run_rasterizer_tb;

    typedef struct {
        logic [glr_pkg::OUT_W-1:0] left;
        logic [glr_pkg::OUT_W-1:0] top;
        logic [glr_pkg::OUT_W-1:0] width;
        logic [glr_pkg::OUT_W-1:0] height;
        logic                      last;
    } t_rect;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [glr_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [9:0]                i_first_x = '0;
    logic [9:0]                i_first_y = '0;
    logic [9:0]                i_second_x = '0;
    logic [9:0]                i_second_y = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [glr_pkg::OUT_W-1:0] o_rect_left;
    logic [glr_pkg::OUT_W-1:0] o_rect_top;
    logic [glr_pkg::OUT_W-1:0] o_rect_width;
    logic [glr_pkg::OUT_W-1:0] o_rect_height;
    logic                      o_last_rect;

    t_rect       pending_rects[$];
    int          cell_edge = 16;
    int          error_count = 0;
    longint      cycle_count = 0;
    int          hold_cycles = 0;
    int          stall_mode = 0;
    int          burst_left = 0;

    grid_line_run_rasterizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_first_x(i_first_x),
        .i_first_y(i_first_y), .i_second_x(i_second_x), .i_second_y(i_second_y),
        .o_valid(o_valid), .i_stall(i_stall), .o_rect_left(o_rect_left),
        .o_rect_top(o_rect_top), .o_rect_width(o_rect_width),
        .o_rect_height(o_rect_height), .o_last_rect(o_last_rect)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint floor_q(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint ceil_q(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n > 0) q++;
        return q;
    endfunction

    function automatic longint snap_edge(longint n, longint d, longint c, bit up);
        longint den;
        den = d * c;
        if (den < 0) begin
            n = -n;
            den = -den;
        end
        return (up ? ceil_q(n, den) : floor_q(n, den)) * c;
    endfunction

    function automatic logic [glr_pkg::OUT_W-1:0] clamp_out(longint v);
        if (v < 0) return '0;
        if (v > 2047) return 11'd2047;
        return v[glr_pkg::OUT_W-1:0];
    endfunction

    function automatic void add_rect(longint l, longint t, longint w, longint h, bit last);
        t_rect r;
        r.left = clamp_out(l);
        r.top = clamp_out(t);
        r.width = clamp_out(w);
        r.height = clamp_out(h);
        r.last = last;
        pending_rects.push_back(r);
    endfunction

    function automatic void predict_stair(longint ax, longint ay, longint bx, longint by);
        longint c, sx, ex, sy, ey, dx, dy, stp, x1, y1, x2, y2, prv, p, n, nxt;
        bit pos, up, last;
        int k;
        c = (cell_edge < 16) ? 16 : cell_edge;
        sx = ((ax < bx ? ax : bx) / c) * c;
        ex = (((ax > bx ? ax : bx) + c - 1) / c) * c;
        sy = ((ay < by ? ay : by) / c) * c;
        ey = (((ay > by ? ay : by) + c - 1) / c) * c;
        if (ex - sx <= c || ey - sy <= c) begin
            add_rect(sx, sy, ex - sx, ey - sy, 1'b1);
            return;
        end
        dx = ax > bx ? ax - bx : bx - ax;
        dy = ay > by ? ay - by : by - ay;
        pos = (ax == bx) || (ay == by) || ((ax > bx) == (ay > by));
        stp = pos ? c : -c;
        k = 0;
        if (dx < dy) begin
            x1 = pos ? sx : ex; y1 = sy; x2 = pos ? ex : sx; y2 = ey;
            up = ay <= by;
            prv = y1;
            for (p = x1 + stp; pos ? p < x2 : p > x2; p += stp) begin
                n = x1 * y2 - y1 * x2 + p * (y1 - y2);
                nxt = snap_edge(n, x1 - x2, c, up);
                last = (k == 63);
                add_rect(pos ? p - c : p, prv, c, nxt - prv, last);
                k++;
                if (last) return;
                prv = nxt;
            end
            add_rect(pos ? p - c : p, prv, c, y2 - prv, 1'b1);
        end else begin
            x1 = sx; y1 = pos ? sy : ey; x2 = ex; y2 = pos ? ey : sy;
            up = ax <= bx;
            prv = x1;
            for (p = y1 + stp; pos ? p < y2 : p > y2; p += stp) begin
                n = p * (x1 - x2) - (x1 * y2 - y1 * x2);
                nxt = snap_edge(n, y1 - y2, c, up);
                last = (k == 63);
                add_rect(prv, pos ? p - c : p, nxt - prv, c, last);
                k++;
                if (last) return;
                prv = nxt;
            end
            add_rect(prv, pos ? p - c : p, x2 - prv, c, 1'b1);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_rect w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rects.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = pending_rects.pop_front();
                if (o_rect_left !== w.left) report_mismatch("left", o_rect_left, w.left);
                if (o_rect_top !== w.top) report_mismatch("top", o_rect_top, w.top);
                if (o_rect_width !== w.width)
                    report_mismatch("width", o_rect_width, w.width);
                if (o_rect_height !== w.height)
                    report_mismatch("height", o_rect_height, w.height);
                if (o_last_rect !== w.last) report_mismatch("last", o_last_rect, w.last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic send_segment(input logic [9:0] ax, ay, bx, by, input bit gaps);
        int g;
        if (gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
                if (g > 0) begin
                    i_valid <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
            end
            burst_left--;
        end
        i_valid <= 1'b1;
        i_first_x <= ax;
        i_first_y <= ay;
        i_second_x <= bx;
        i_second_y <= by;
        predict_stair(ax, ay, bx, by);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (pending_rects.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_cell_size(input logic [glr_pkg::CFG_W-1:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cell_edge = v;
    endtask

    task automatic test_directed;
        send_segment(0, 0, 0, 0, 0);
        send_segment(1023, 1023, 1023, 1023, 0);
        send_segment(0, 0, 1023, 1023, 0);
        send_segment(1023, 1023, 0, 0, 0);
        send_segment(0, 1023, 1023, 0, 0);
        send_segment(1023, 0, 0, 1023, 0);
        send_segment(0, 500, 1023, 500, 0);
        send_segment(500, 0, 500, 1023, 0);
        send_segment(10, 20, 900, 100, 0);
        send_segment(900, 100, 10, 20, 0);
        send_segment(20, 10, 100, 900, 0);
        send_segment(100, 900, 20, 10, 0);
        send_segment(5, 5, 40, 9, 0);
        send_segment(682, 341, 341, 682, 0);
    endtask

    task automatic test_config_extremes;
        write_cell_size(8'd0);
        send_segment(0, 0, 1023, 700, 0);
        write_cell_size(8'd15);
        send_segment(1023, 0, 3, 1000, 0);
        write_cell_size(8'd255);
        send_segment(0, 0, 1023, 1023, 0);
        send_segment(1023, 100, 0, 900, 0);
        send_segment(300, 300, 200, 200, 0);
        write_cell_size(8'd17);
        send_segment(1, 2, 1022, 1021, 0);
    endtask

    task automatic send_random(input int count, input bit well_formed);
        logic [9:0] ax, ay, bx, by;
        repeat (count) begin
            ax = 10'($urandom);
            ay = 10'($urandom);
            if (well_formed && $urandom_range(0, 3) != 0) begin
                bx = $urandom_range(0, 1) ? 10'($urandom_range(0, 200))
                                          : 10'($urandom_range(823, 1023));
                by = 10'($urandom);
            end else begin
                bx = 10'($urandom);
                by = 10'($urandom);
            end
            send_segment(ax, ay, bx, by, 1);
        end
    endtask

    task automatic test_random;
        write_cell_size(8'd16);
        send_random(120, 1);
        write_cell_size(8'($urandom_range(16, 255)));
        send_random(60, 0);
        write_cell_size(8'($urandom_range(32, 96)));
        send_random(100, 1);
        write_cell_size(8'($urandom_range(0, 15)));
        send_random(40, 0);
    endtask

    task automatic test_backpressure;
        write_cell_size(8'd16);
        hold_cycles = 6000;
        send_random(8, 0);
        wait_drained();
        send_random(10, 1);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        wait_drained();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[grid_line_run_rasterizer.f]
rtl/glr_pkg.sv
rtl/glr_div.sv
rtl/glr_front.sv
rtl/glr_fifo.sv
rtl/glr_back.sv
rtl/grid_line_run_rasterizer.sv
sim/grid_line_run_rasterizer_tb.sv
